// ===== hw/rtl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg: shared definitions for the roulette wheel selector
// Widths, request codes, sequencer states and the control/status structs
// passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package rws_pkg;

    // slot store geometry
    localparam int MAX_POP  = 64;
    localparam int SLOT_W   = $clog2(MAX_POP);
    localparam int FIT_W    = 32;

    // running total holds the sum of every slot without overflow
    localparam int TOTAL_W  = FIT_W + SLOT_W;

    // request fields and configuration
    localparam int DRAW_W   = 7;
    localparam int POP_W    = 7;
    localparam logic [POP_W-1:0] POP_RESET = 7'd50;
    localparam logic [POP_W-1:0] POP_LIMIT = POP_W'(MAX_POP);

    // fitness times the percent scale
    localparam int PROD_W   = FIT_W + 7;

    // both sides of draw*total < 100*cumulative
    localparam int ACC_W    = TOTAL_W + 7;

    // padded stream widths
    localparam int S_DATA_W = ((SLOT_W + FIT_W + DRAW_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SLOT_W + 7) / 8) * 8;

    // request kinds carried in the slave-side tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_SEL_RUN,
        ST_DONE
    } state_t;

    // sequencer to datapath
    typedef struct packed {
        logic              cap;       // capture the accepted transaction
        logic              rd_walk;   // read address from the walk counter
        logic [SLOT_W-1:0] walk_idx;  // walk read address
        logic              ld_write;  // commit a load
        logic              acc_en;    // accumulate one slot and test it
    } dp_cmd_t;

    // datapath to sequencer
    typedef struct packed {
        logic total_zero;
        logic hit;
    } dp_stat_t;

endpackage

// ===== hw/rtl/roulette_wheel_selector.sv =====
// ----------------------------------------------------------------------------
// roulette_wheel_selector: fitness-proportionate slot selector
// Stores one 16.16 fitness per slot with a running total and picks the
// first slot whose cumulative fitness passes a percentage draw.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one transaction per request. tuser selects a
//   load (0), which writes fitness_value into slot, or a selection (1),
//   which uses draw. Every request returns one master stream transaction:
//   chosen_slot in tdata and found in tuser (both zero for a load).
//   population_size is written on the cfg channel while the block is idle.
// Timing:
//   A load goes through a memory read (LOAD_RD) and a write (LOAD_WR) to
//   DONE. A selection walks the slots until one hits or the last is
//   tested, or goes to DONE directly when the total or population size
//   is zero. The walk reads one slot per cycle from the single read port
//   of the fitness memory, so that port sets the selection time. One
//   request is in flight at a time; s_tready is high only when idle.
// Reset and stall:
//   Reset empties the fitness store (per-slot valid bits), clears the
//   total and sets population_size to 50. A result held by a stalled
//   receiver stays in the output register; the next request is still
//   accepted and waits for the register before its result is placed.
// ----------------------------------------------------------------------------
module roulette_wheel_selector (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [5:0] slot, [37:6] fitness_value, [44:38] draw, [47:45] zero
    input  logic [rws_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] req_type
    input  logic                          s_tuser,
    // master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] chosen_slot, [7:6] zero
    output logic [rws_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] found
    output logic                          m_tuser,
    // configuration write channel: population_size
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rws_pkg::POP_W-1:0]     cfg_data
);

    rws_pkg::dp_cmd_t           cmd;
    rws_pkg::dp_stat_t          stat;
    logic [rws_pkg::POP_W-1:0]  pop_reg;
    logic [rws_pkg::SLOT_W-1:0] slot_in;
    logic [rws_pkg::FIT_W-1:0]  fit_in;
    logic [rws_pkg::DRAW_W-1:0] draw_in;
    logic [rws_pkg::SLOT_W-1:0] out_slot;

    // unpack the request
    assign slot_in = s_tdata[rws_pkg::SLOT_W-1:0];
    assign fit_in  = s_tdata[rws_pkg::SLOT_W+rws_pkg::FIT_W-1:rws_pkg::SLOT_W];
    assign draw_in = s_tdata[rws_pkg::SLOT_W+rws_pkg::FIT_W+rws_pkg::DRAW_W-1:
                             rws_pkg::SLOT_W+rws_pkg::FIT_W];

    // population size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg <= rws_pkg::POP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pop_reg <= cfg_data;
        end
    end

    rws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .req_type  (s_tuser),
        .pop       (pop_reg),
        .stat      (stat),
        .m_tready  (m_tready),
        .s_tready  (s_tready),
        .cmd       (cmd),
        .out_valid (m_tvalid),
        .out_slot  (out_slot),
        .out_found (m_tuser)
    );

    rws_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .slot_in (slot_in),
        .fit_in  (fit_in),
        .draw_in (draw_in),
        .stat    (stat)
    );

    // pack the result
    assign m_tdata = rws_pkg::M_DATA_W'(out_slot);

endmodule

// ===== hw/rtl/rws_ram.sv =====
// ----------------------------------------------------------------------------
// rws_ram: generic single write, single read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rws_dp.sv =====
// ----------------------------------------------------------------------------
// rws_dp: fitness store and shared accumulate/compare unit
// Holds the slot memory with per-slot valid bits, the running total and
// the walk accumulator that tests one slot per cycle.
// ----------------------------------------------------------------------------
module rws_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rws_pkg::dp_cmd_t            cmd,
    input  logic [rws_pkg::SLOT_W-1:0]  slot_in,
    input  logic [rws_pkg::FIT_W-1:0]   fit_in,
    input  logic [rws_pkg::DRAW_W-1:0]  draw_in,
    output rws_pkg::dp_stat_t           stat
);

    logic [rws_pkg::SLOT_W-1:0]  slot_reg;
    logic [rws_pkg::FIT_W-1:0]   fit_reg;
    logic [rws_pkg::ACC_W-1:0]   lhs_reg;
    logic [rws_pkg::TOTAL_W-1:0] total_reg;
    logic [rws_pkg::TOTAL_W-1:0] total_next;
    logic [rws_pkg::MAX_POP-1:0] valid_reg;
    logic                        vld_q_reg;
    logic [rws_pkg::PROD_W-1:0]  prod_reg;
    logic [rws_pkg::PROD_W-1:0]  prod_next;
    logic [rws_pkg::ACC_W-1:0]   acc_reg;
    logic [rws_pkg::ACC_W-1:0]   acc_sum;
    logic [rws_pkg::SLOT_W-1:0]  rd_addr;
    logic [rws_pkg::FIT_W-1:0]   rdata;
    logic [rws_pkg::FIT_W-1:0]   data;

    // fitness memory
    rws_ram #(
        .WIDTH (rws_pkg::FIT_W),
        .DEPTH (rws_pkg::MAX_POP)
    ) u_store (
        .clk   (clk),
        .we    (cmd.ld_write),
        .waddr (slot_reg),
        .wdata (fit_reg),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign rd_addr = cmd.rd_walk ? cmd.walk_idx : slot_reg;

    // a slot never written since reset reads as zero
    assign data = vld_q_reg ? rdata : '0;

    // times 100 as shift and add
    assign prod_next = (rws_pkg::PROD_W'(data) << 6) + (rws_pkg::PROD_W'(data) << 5)
                     + (rws_pkg::PROD_W'(data) << 2);

    // shared add and compare
    assign acc_sum   = acc_reg + rws_pkg::ACC_W'(prod_reg);
    assign stat.hit  = (lhs_reg < acc_sum);
    assign stat.total_zero = (total_reg == '0);

    // total correction: drop the old value, add the new one
    assign total_next = total_reg - rws_pkg::TOTAL_W'(data) + rws_pkg::TOTAL_W'(fit_reg);

    // transaction capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            slot_reg <= slot_in;
            fit_reg  <= fit_in;
            lhs_reg  <= rws_pkg::ACC_W'(total_reg) * rws_pkg::ACC_W'(draw_in);
        end
        prod_reg <= prod_next;
    end

    // walk accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_sum;
        end
    end

    // total, valid bits and the valid bit of the slot being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            vld_q_reg <= valid_reg[rd_addr];
            if (cmd.ld_write)
            begin
                total_reg           <= total_next;
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/rws_ctrl.sv =====
// ----------------------------------------------------------------------------
// rws_ctrl: sequencer for loads and selections
// Steps a load through read and write, walks the slots of a selection
// through the read and multiply stages, and holds the output register.
// ----------------------------------------------------------------------------
module rws_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        req_type,
    input  logic [rws_pkg::POP_W-1:0]   pop,
    input  rws_pkg::dp_stat_t           stat,
    input  logic                        m_tready,
    output logic                        s_tready,
    output rws_pkg::dp_cmd_t            cmd,
    output logic                        out_valid,
    output logic [rws_pkg::SLOT_W-1:0]  out_slot,
    output logic                        out_found
);

    rws_pkg::state_t state_reg;
    rws_pkg::state_t state_next;

    logic [rws_pkg::POP_W-1:0]  n_in;
    logic [rws_pkg::POP_W-1:0]  n_reg;
    logic [rws_pkg::POP_W-1:0]  rd_cnt_reg;
    logic                       issue;
    logic                       p1_vld_reg;
    logic [rws_pkg::SLOT_W-1:0] p1_idx_reg;
    logic                       p2_vld_reg;
    logic [rws_pkg::SLOT_W-1:0] p2_idx_reg;
    logic                       p2_last;
    logic                       p2_hit;
    logic [rws_pkg::SLOT_W-1:0] res_slot_reg;
    logic                       res_found_reg;
    logic                       out_valid_reg;
    logic [rws_pkg::SLOT_W-1:0] out_slot_reg;
    logic                       out_found_reg;
    logic                       out_load;

    // walk length clamped to the store depth
    assign n_in    = (pop > rws_pkg::POP_LIMIT) ? rws_pkg::POP_LIMIT : pop;
    assign issue   = (state_reg == rws_pkg::ST_SEL_RUN) && (rd_cnt_reg < n_reg);
    assign p2_last = ({1'b0, p2_idx_reg} == (n_reg - 7'd1));
    assign p2_hit  = p2_vld_reg && stat.hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rws_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (req_type == rws_pkg::REQ_LOAD)
                    begin
                        state_next = rws_pkg::ST_LOAD_RD;
                    end
                    else if (stat.total_zero || (n_in == '0))
                    begin
                        state_next = rws_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = rws_pkg::ST_SEL_RUN;
                    end
                end
            end
            rws_pkg::ST_LOAD_RD:
            begin
                state_next = rws_pkg::ST_LOAD_WR;
            end
            rws_pkg::ST_LOAD_WR:
            begin
                state_next = rws_pkg::ST_DONE;
            end
            rws_pkg::ST_SEL_RUN:
            begin
                if (p2_vld_reg && (stat.hit || p2_last))
                begin
                    state_next = rws_pkg::ST_DONE;
                end
            end
            rws_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = rws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rws_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready     = (state_reg == rws_pkg::ST_IDLE);
        cmd.cap      = (state_reg == rws_pkg::ST_IDLE) && s_tvalid;
        cmd.rd_walk  = (state_reg == rws_pkg::ST_SEL_RUN);
        cmd.walk_idx = rd_cnt_reg[rws_pkg::SLOT_W-1:0];
        cmd.ld_write = (state_reg == rws_pkg::ST_LOAD_WR);
        cmd.acc_en   = (state_reg == rws_pkg::ST_SEL_RUN) && p2_vld_reg;
        out_load     = (state_reg == rws_pkg::ST_DONE) && (!out_valid_reg || m_tready);
    end

    // state, walk counter and stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rws_pkg::ST_IDLE;
            n_reg      <= '0;
            rd_cnt_reg <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p1_idx_reg <= '0;
            p2_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.cap)
            begin
                n_reg      <= n_in;
                rd_cnt_reg <= '0;
                p1_vld_reg <= 1'b0;
                p2_vld_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 7'd1;
                end
                p1_vld_reg <= issue;
                p1_idx_reg <= rd_cnt_reg[rws_pkg::SLOT_W-1:0];
                p2_vld_reg <= p1_vld_reg && (state_reg == rws_pkg::ST_SEL_RUN);
                p2_idx_reg <= p1_idx_reg;
            end
        end
    end

    // pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_slot_reg  <= '0;
            res_found_reg <= 1'b0;
        end
        else if (cmd.cap)
        begin
            res_slot_reg  <= '0;
            res_found_reg <= 1'b0;
        end
        else if ((state_reg == rws_pkg::ST_SEL_RUN) && p2_hit)
        begin
            res_slot_reg  <= p2_idx_reg;
            res_found_reg <= 1'b1;
        end
    end

    // output register toward the master side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_slot_reg  <= '0;
            out_found_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            out_slot_reg  <= res_slot_reg;
            out_found_reg <= res_found_reg;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_found = out_found_reg;

endmodule
